// ===== design/mm_pkg.sv =====
package mm_pkg;

  localparam int MAX_DIM     = 8;
  localparam int DIM_CAP     = (MAX_DIM < 8) ? MAX_DIM : 8;
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int IDX_W       = $clog2(DIM_CAP);
  localparam int DIM_W       = $clog2(DIM_CAP + 1);
  localparam int DATA_W      = 32;
  localparam int PROD_W      = 64;
  localparam int ACC_W       = PROD_W + $clog2(DIM_CAP) + 1;
  localparam int FRAC_W      = 16;
  localparam int PADDR_W     = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] MODE_LOAD_A = 2'd0;
  localparam logic [1:0] MODE_LOAD_B = 2'd1;
  localparam logic [1:0] MODE_START  = 2'd2;

  localparam logic [1:0] REG_ROWS_A    = 2'd0;
  localparam logic [1:0] REG_INNER_DIM = 2'd1;
  localparam logic [1:0] REG_COLS_B    = 2'd2;

  localparam logic [DATA_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] SAT_NEG = 32'h8000_0000;

  typedef enum logic [1:0] {
    CMD_LOAD_A,
    CMD_LOAD_B,
    CMD_START
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [AW-1:0]     addr;
    logic [DATA_W-1:0] value;
    logic [DIM_W-1:0]  nr;
    logic [DIM_W-1:0]  nk;
    logic [DIM_W-1:0]  nc;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_status_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [3:0] r);
    logic [DIM_W-1:0] res;
    if (r == 4'd0) begin
      res = DIM_W'(1);
    end else if (32'(r) > DIM_CAP) begin
      res = DIM_W'(DIM_CAP);
    end else begin
      res = DIM_W'(r);
    end
    return res;
  endfunction

endpackage

// ===== design/mm_ram.sv =====
module mm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/mm_front.sv =====
module mm_front import mm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [1:0]         mode_i,
  input  logic [2:0]         row_i,
  input  logic [2:0]         col_i,
  input  logic [DATA_W-1:0]  value_i,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  q_status_t          q_status_i,
  output logic               push_o,
  output cmd_t               cmd_o
);

  logic [3:0] rows_a_q, rows_a_d;
  logic [3:0] inner_dim_q, inner_dim_d;
  logic [3:0] cols_b_q, cols_b_d;
  logic       wr_en;
  logic       in_range;
  logic       keep;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    rows_a_d    = rows_a_q;
    inner_dim_d = inner_dim_q;
    cols_b_d    = cols_b_q;
    if (wr_en) begin
      case (paddr[3:2])
        REG_ROWS_A:    rows_a_d    = pwdata[3:0];
        REG_INNER_DIM: inner_dim_d = pwdata[3:0];
        REG_COLS_B:    cols_b_d    = pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q    <= 4'd8;
      inner_dim_q <= 4'd8;
      cols_b_q    <= 4'd8;
    end else begin
      rows_a_q    <= rows_a_d;
      inner_dim_q <= inner_dim_d;
      cols_b_q    <= cols_b_d;
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ROWS_A:    prdata = {28'd0, rows_a_q};
      REG_INNER_DIM: prdata = {28'd0, inner_dim_q};
      REG_COLS_B:    prdata = {28'd0, cols_b_q};
      default:       prdata = 32'd0;
    endcase
  end

  assign in_range = (32'(row_i) < DIM_CAP) && (32'(col_i) < DIM_CAP);

  always_comb begin
    cmd_o.kind  = CMD_START;
    cmd_o.addr  = AW'(row_i) * AW'(MAX_DIM) + AW'(col_i);
    cmd_o.value = value_i;
    cmd_o.nr    = eff_dim(rows_a_q);
    cmd_o.nk    = eff_dim(inner_dim_q);
    cmd_o.nc    = eff_dim(cols_b_q);
    keep        = 1'b0;
    case (mode_i)
      MODE_LOAD_A: begin
        cmd_o.kind = CMD_LOAD_A;
        keep       = in_range;
      end
      MODE_LOAD_B: begin
        cmd_o.kind = CMD_LOAD_B;
        keep       = in_range;
      end
      MODE_START: begin
        cmd_o.kind = CMD_START;
        keep       = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign push_o = in_valid_i && !q_status_i.full && keep;

endmodule

// ===== design/mm_queue.sv =====
module mm_queue import mm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  cmd_t      cmd_i,
  input  logic      pop_i,
  output q_status_t status_o,
  output cmd_t      cmd_o
);

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_push;
  logic              do_pop;

  assign status_o.full  = (32'(count_q) == QUEUE_DEPTH);
  assign status_o.valid = (count_q != '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && status_o.valid;
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== design/mm_back.sv =====
module mm_back import mm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  cmd_t              cmd_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        out_row_o,
  output logic [2:0]        out_col_o,
  output logic [DATA_W-1:0] product_o,
  output logic              saturated_o,
  output logic              last_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_DRAIN
  } state_e;

  state_e            state_q;
  logic [IDX_W-1:0]  i_q, j_q, k_q;
  logic [DIM_W-1:0]  nr_q, nk_q, nc_q;
  logic              out_valid_q;
  logic [2:0]        out_row_q, out_col_q;
  logic [DATA_W-1:0] out_prod_q;
  logic              out_sat_q, out_last_q;

  logic              iss_vld_q, iss_first_q, iss_last_q;
  logic              mul_vld_q, mul_first_q, mul_last_q;
  logic [PROD_W-1:0] prod_q;
  logic [ACC_W-1:0]  acc_q;
  logic              acc_done_q;

  logic              issue, take, k_last, i_last, j_last;
  logic              we_a, we_b;
  logic [AW-1:0]     raddr_a, raddr_b;
  logic [DATA_W-1:0] rdata_a, rdata_b;
  logic signed [PROD_W-1:0] op_a, op_b;
  logic [ACC_W-FRAC_W-DATA_W:0] acc_top;
  logic              fits;
  logic [DATA_W-1:0] res;

  assign issue  = (state_q == S_ISSUE);
  assign k_last = (DIM_W'(k_q) == nk_q - DIM_W'(1));
  assign i_last = (DIM_W'(i_q) == nr_q - DIM_W'(1));
  assign j_last = (DIM_W'(j_q) == nc_q - DIM_W'(1));
  assign take   = (state_q == S_DRAIN) && acc_done_q && (!out_valid_q || !out_stall_i);
  assign pop_o  = (state_q == S_IDLE) && q_valid_i;
  assign we_a   = pop_o && (cmd_i.kind == CMD_LOAD_A);
  assign we_b   = pop_o && (cmd_i.kind == CMD_LOAD_B);

  assign raddr_a = AW'(i_q) * AW'(MAX_DIM) + AW'(k_q);
  assign raddr_b = AW'(k_q) * AW'(MAX_DIM) + AW'(j_q);

  mm_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (cmd_i.addr),
    .wdata_i (cmd_i.value),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  mm_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (cmd_i.addr),
    .wdata_i (cmd_i.value),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  assign op_a = {{(PROD_W-DATA_W){rdata_a[DATA_W-1]}}, rdata_a};
  assign op_b = {{(PROD_W-DATA_W){rdata_b[DATA_W-1]}}, rdata_b};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_vld_q  <= 1'b0;
      mul_vld_q  <= 1'b0;
      acc_done_q <= 1'b0;
    end else begin
      iss_vld_q <= issue;
      mul_vld_q <= iss_vld_q;
      if (take) begin
        acc_done_q <= 1'b0;
      end else if (mul_vld_q && mul_last_q) begin
        acc_done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    iss_first_q <= (k_q == '0);
    iss_last_q  <= k_last;
    mul_first_q <= iss_first_q;
    mul_last_q  <= iss_last_q;
    prod_q      <= PROD_W'(op_a * op_b);
    if (mul_vld_q) begin
      acc_q <= (mul_first_q ? '0 : acc_q) + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
  end

  // The shifted sum fits in 32 bits only when every bit above bit 46 matches the sign.
  assign acc_top = acc_q[ACC_W-1:FRAC_W+DATA_W-1];
  assign fits    = (&acc_top) || !(|acc_top);
  assign res     = fits ? acc_q[FRAC_W+DATA_W-1:FRAC_W]
                        : (acc_q[ACC_W-1] ? SAT_NEG : SAT_POS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
    end else begin
      if (take) begin
        out_valid_q <= 1'b1;
        out_row_q   <= 3'(i_q);
        out_col_q   <= 3'(j_q);
        out_prod_q  <= res;
        out_sat_q   <= !fits;
        out_last_q  <= i_last && j_last;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (pop_o && (cmd_i.kind == CMD_START)) begin
            nr_q    <= cmd_i.nr;
            nk_q    <= cmd_i.nk;
            nc_q    <= cmd_i.nc;
            i_q     <= '0;
            j_q     <= '0;
            k_q     <= '0;
            state_q <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          if (k_last) begin
            k_q     <= '0;
            state_q <= S_DRAIN;
          end else begin
            k_q <= k_q + IDX_W'(1);
          end
        end
        S_DRAIN: begin
          if (take) begin
            if (i_last && j_last) begin
              state_q <= S_IDLE;
            end else begin
              if (j_last) begin
                j_q <= '0;
                i_q <= i_q + IDX_W'(1);
              end else begin
                j_q <= j_q + IDX_W'(1);
              end
              state_q <= S_ISSUE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign product_o   = out_prod_q;
  assign saturated_o = out_sat_q;
  assign last_o      = out_last_q;

endmodule

// ===== design/matrix_multiply_unit.sv =====
// Loads of A or B are written to their operand store in the cycle they are dequeued,
// which happens only while the execution unit is idle. A start beat gives rows_a * cols_b
// results, computed in turn by one shared 32 x 32 multiplier fed from one read port on
// each operand store.
// Reset is asynchronous and active low; it empties the queue and sets all dimensions to 8.
// The operand stores are not cleared and hold no defined value until written.
module matrix_multiply_unit import mm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic [2:0]         row_i,
  input  logic [2:0]         col_i,
  input  logic [DATA_W-1:0]  value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         out_row_o,
  output logic [2:0]         out_col_o,
  output logic [DATA_W-1:0]  product_o,
  output logic               saturated_o,
  output logic               last_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  q_status_t q_status;
  logic      push, pop;
  cmd_t      cmd_in, cmd_head;

  assign in_stall_o = q_status.full;

  mm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (mode_i),
    .row_i      (row_i),
    .col_i      (col_i),
    .value_i    (value_i),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .q_status_i (q_status),
    .push_o     (push),
    .cmd_o      (cmd_in)
  );

  mm_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (cmd_in),
    .pop_i    (pop),
    .status_o (q_status),
    .cmd_o    (cmd_head)
  );

  mm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_status.valid),
    .cmd_i       (cmd_head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .product_o   (product_o),
    .saturated_o (saturated_o),
    .last_o      (last_o)
  );

endmodule

// ===== design/mm_checker.sv =====
module mm_checker import mm_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [2:0]         out_row_o,
  input logic [2:0]         out_col_o,
  input logic [DATA_W-1:0]  product_o,
  input logic               saturated_o,
  input logic               last_o
);

  logic expect_first_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_first_q <= 1'b1;
    end else if (out_valid_o && !out_stall_i) begin
      expect_first_q <= last_o;
    end
  end

  // The first beat of every result starts at the top left element.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && expect_first_q |-> (out_row_o == 3'd0) && (out_col_o == 3'd0))
    else $error("result does not start at row 0, column 0");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> (product_o == SAT_POS) || (product_o == SAT_NEG))
    else $error("saturated beat carries an unclipped value");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(product_o) && $stable(last_o))
    else $error("stalled result beat changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o && !out_stall_i |=> !(out_valid_o && expect_first_q))
    else $error("result sequence restarted before its last beat");

endmodule

bind matrix_multiply_unit mm_checker u_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import mm_pkg::*;

  localparam logic [1:0] MODE_UNUSED     = 2'd3;
  localparam int         RANDOM_ITEMS    = 430;
  localparam int         SETTLE_CYCLES   = 16;
  localparam int         END_CYCLES      = 40;
  localparam int         HOLD_OFF_CYCLES = 400;
  localparam int         WATCHDOG_LIMIT  = 3000;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_style_e;

  typedef struct {
    logic [2:0]        row;
    logic [2:0]        col;
    logic [DATA_W-1:0] value;
    logic              sat;
    logic              last;
  } product_elem_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic [1:0]         mode_i      = MODE_LOAD_A;
  logic [2:0]         row_i       = '0;
  logic [2:0]         col_i       = '0;
  logic [DATA_W-1:0]  value_i     = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [2:0]         out_row_o;
  logic [2:0]         out_col_o;
  logic [DATA_W-1:0]  product_o;
  logic               saturated_o;
  logic               last_o;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [PADDR_W-1:0] paddr       = '0;
  logic [31:0]        pwdata      = '0;
  logic [31:0]        prdata;
  logic               pready;

  logic signed [DATA_W-1:0] a_elems [DIM_CAP][DIM_CAP];
  logic signed [DATA_W-1:0] b_elems [DIM_CAP][DIM_CAP];
  bit                       a_written [DIM_CAP][DIM_CAP];
  bit                       b_written [DIM_CAP][DIM_CAP];
  logic [3:0]               rows_a_reg    = 4'd8;
  logic [3:0]               inner_dim_reg = 4'd8;
  logic [3:0]               cols_b_reg    = 4'd8;

  product_elem_t pending_elems [$];
  int            err_count    = 0;
  int            items_sent   = 0;
  int            burst_left   = 0;
  bit            sender_gaps  = 1'b1;
  bit            hold_off_req = 1'b0;

  matrix_multiply_unit i_dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic int clamp_dim(input logic [3:0] code);
    if (code == 4'd0) return 1;
    return (int'(code) > DIM_CAP) ? DIM_CAP : int'(code);
  endfunction

  function automatic logic [3:0] pick_dim_code();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return 4'd0;
    if (pick == 1) return 4'($urandom_range(9, 15));
    if (pick < 4) return 4'd8;
    if (pick < 8) return 4'($urandom_range(4, 7));
    return 4'($urandom_range(1, 3));
  endfunction

  function automatic logic [DATA_W-1:0] rand_value();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = SAT_POS;
      1:       v = SAT_NEG;
      2:       v = '0;
      3, 4:    v = $urandom;
      8:       v = 32'($urandom_range(0, 7)) - 32'd4;
      9: begin
        v = $urandom & 32'h00FF_FFFF;
        if ($urandom_range(0, 1)) v = -v;
      end
      default: v = 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
    endcase
    return v;
  endfunction

  // Each sum is formed exactly in 128 bits before scaling and clipping.
  function automatic void predict_matrix_product();
    int                  nr, nk, nc;
    logic signed [127:0] acc, scaled, hi_lim, lo_lim;
    product_elem_t       e;
    nr = clamp_dim(rows_a_reg);
    nk = clamp_dim(inner_dim_reg);
    nc = clamp_dim(cols_b_reg);
    hi_lim = 128'sh7FFF_FFFF;
    lo_lim = -hi_lim - 128'sd1;
    for (int i = 0; i < nr; i++) begin
      for (int j = 0; j < nc; j++) begin
        acc = '0;
        for (int k = 0; k < nk; k++) begin
          acc = acc + 128'(longint'(a_elems[i][k]) * longint'(b_elems[k][j]));
        end
        scaled = acc >>> FRAC_W;
        e.row  = 3'(i);
        e.col  = 3'(j);
        if (scaled > hi_lim) begin
          e.value = SAT_POS;
          e.sat   = 1'b1;
        end else if (scaled < lo_lim) begin
          e.value = SAT_NEG;
          e.sat   = 1'b1;
        end else begin
          e.value = scaled[DATA_W-1:0];
          e.sat   = 1'b0;
        end
        e.last = (i == nr - 1) && (j == nc - 1);
        pending_elems.push_back(e);
      end
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      err_count++;
    end
  endfunction

  task automatic send_beat(input logic [1:0] mode, input logic [2:0] row,
                           input logic [2:0] col, input logic [DATA_W-1:0] value);
    int gap;
    if (burst_left == 0) begin
      gap        = sender_gaps ? $urandom_range(1, 12) : 0;
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    row_i      <= row;
    col_i      <= col;
    value_i    <= value;
    do @(posedge clk_i); while (in_stall_o);
    case (mode)
      MODE_LOAD_A: begin
        if (row < DIM_CAP && col < DIM_CAP) begin
          a_elems[row][col]   = value;
          a_written[row][col] = 1'b1;
        end
      end
      MODE_LOAD_B: begin
        if (row < DIM_CAP && col < DIM_CAP) begin
          b_elems[row][col]   = value;
          b_written[row][col] = 1'b1;
        end
      end
      MODE_START: predict_matrix_product();
      default: ;
    endcase
    if (mode != MODE_UNUSED) items_sent++;
  endtask

  task automatic settle_block();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_elems.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_dim_reg(input logic [1:0] idx, input logic [3:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= 32'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_ROWS_A:    rows_a_reg    = val;
      REG_INNER_DIM: inner_dim_reg = val;
      REG_COLS_B:    cols_b_reg    = val;
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    psel <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    check_field("register readback", 32'(val), prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_dims(input logic [3:0] r, input logic [3:0] k, input logic [3:0] c);
    settle_block();
    write_dim_reg(REG_ROWS_A, r);
    write_dim_reg(REG_INNER_DIM, k);
    write_dim_reg(REG_COLS_B, c);
  endtask

  // A start may only read elements that have been written at least once.
  task automatic load_missing_operands();
    int nr, nk, nc;
    nr = clamp_dim(rows_a_reg);
    nk = clamp_dim(inner_dim_reg);
    nc = clamp_dim(cols_b_reg);
    for (int i = 0; i < nr; i++) begin
      for (int k = 0; k < nk; k++) begin
        if (!a_written[i][k]) send_beat(MODE_LOAD_A, 3'(i), 3'(k), rand_value());
      end
    end
    for (int k = 0; k < nk; k++) begin
      for (int j = 0; j < nc; j++) begin
        if (!b_written[k][j]) send_beat(MODE_LOAD_B, 3'(k), 3'(j), rand_value());
      end
    end
  endtask

  task automatic test_scalar_extremes();
    logic [DATA_W-1:0] a_vals [5];
    logic [DATA_W-1:0] b_vals [5];
    a_vals = '{SAT_POS, SAT_NEG, SAT_NEG, 32'hFFFF_FFFF, 32'h0001_0000};
    b_vals = '{SAT_POS, SAT_NEG, SAT_POS, 32'h0000_0001, 32'hFFFE_8000};
    set_dims(4'd1, 4'd1, 4'd1);
    sender_gaps = 1'b1;
    foreach (a_vals[n]) begin
      send_beat(MODE_LOAD_A, 3'd0, 3'd0, a_vals[n]);
      send_beat(MODE_LOAD_B, 3'd0, 3'd0, b_vals[n]);
      send_beat(MODE_START, 3'd0, 3'd0, '0);
    end
  endtask

  task automatic test_dims_and_ignored();
    set_dims(4'd0, 4'd1, 4'd2);
    send_beat(MODE_LOAD_A, 3'd7, 3'd7, SAT_NEG);
    send_beat(MODE_LOAD_B, 3'd7, 3'd7, SAT_POS);
    send_beat(MODE_LOAD_B, 3'd0, 3'd1, 32'hFFFE_8000);
    send_beat(MODE_UNUSED, 3'd7, 3'd7, 32'hFFFF_FFFF);
    send_beat(MODE_START, 3'd7, 3'd7, 32'hFFFF_FFFF);
  endtask

  task automatic test_hold_off();
    set_dims(4'd2, 4'd2, 4'd2);
    load_missing_operands();
    sender_gaps  = 1'b0;
    hold_off_req = 1'b1;
    repeat (5) begin
      send_beat(MODE_START, 3'($urandom), 3'($urandom), $urandom);
      send_beat(MODE_LOAD_A, 3'($urandom_range(0, 1)), 3'($urandom_range(0, 1)), rand_value());
    end
    settle_block();
  endtask

  task automatic test_random_traffic();
    int         goal, n_loads, nr, nk, nc, r_hi, c_hi;
    logic [1:0] mode;
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      set_dims(pick_dim_code(), pick_dim_code(), pick_dim_code());
      nr = clamp_dim(rows_a_reg);
      nk = clamp_dim(inner_dim_reg);
      nc = clamp_dim(cols_b_reg);
      sender_gaps = ($urandom_range(0, 9) < 7);
      repeat ($urandom_range(1, 3)) begin
        n_loads = $urandom_range(0, 8);
        repeat (n_loads) begin
          if ($urandom_range(0, 11) == 0) begin
            send_beat(MODE_UNUSED, 3'($urandom), 3'($urandom), $urandom);
          end
          mode = $urandom_range(0, 1) ? MODE_LOAD_B : MODE_LOAD_A;
          r_hi = (mode == MODE_LOAD_A) ? nr : nk;
          c_hi = (mode == MODE_LOAD_A) ? nk : nc;
          if ($urandom_range(0, 4) == 0) begin
            send_beat(mode, 3'($urandom), 3'($urandom), rand_value());
          end else begin
            send_beat(mode, 3'($urandom_range(0, r_hi - 1)), 3'($urandom_range(0, c_hi - 1)),
                      rand_value());
          end
        end
        load_missing_operands();
        send_beat(MODE_START, 3'($urandom), 3'($urandom), $urandom);
      end
    end
  endtask

  always @(posedge clk_i) begin
    product_elem_t exp_e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_elems.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got row %0d col %0d value %0h",
                 $time, out_row_o, out_col_o, product_o);
        err_count++;
      end else begin
        exp_e = pending_elems.pop_front();
        check_field("out_row", 32'(exp_e.row), 32'(out_row_o));
        check_field("out_col", 32'(exp_e.col), 32'(out_col_o));
        check_field("product", exp_e.value, product_o);
        check_field("saturated", 32'(exp_e.sat), 32'(saturated_o));
        check_field("last", 32'(exp_e.last), 32'(last_o));
      end
    end
  end

  initial begin
    stall_style_e style;
    int           left, cnt;
    style = STALL_NONE;
    left  = 0;
    cnt   = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        if (left == 0) begin
          style = stall_style_e'($urandom_range(0, 3));
          left  = $urandom_range(20, 300);
        end
        left--;
        cnt++;
        case (style)
          STALL_NONE:  out_stall_i <= 1'b0;
          STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
          default:     out_stall_i <= ((cnt % 7) < 3);
        endcase
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (psel && penable && pready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("matrix_multiply_unit regression: fail");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_scalar_extremes();
    test_dims_and_ignored();
    test_hold_off();
    test_random_traffic();
    settle_block();
    repeat (END_CYCLES) @(posedge clk_i);
    if (pending_elems.size() != 0) begin
      $display("%0t: %0d result beats never arrived", $time, pending_elems.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("matrix_multiply_unit regression: pass");
    end else begin
      $display("matrix_multiply_unit regression: fail");
    end
    $finish;
  end

endmodule
